FILE: rtl/core/mlr_pkg.sv
// Shared types and codes for the message log ring.
`default_nettype none

package mlr_pkg;

    localparam int LEN_W    = 13;
    localparam int SENDER_W = 16;
    localparam int BYTE_W   = 8;
    localparam int MOFF_W   = 6;
    localparam int BOFF_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_OPEN,
        KIND_REJECT,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [LEN_W-1:0]     len;
        logic [SENDER_W-1:0]  sender;
        logic [BYTE_W-1:0]    data;
        logic [MOFF_W-1:0]    moff;
        logic [BOFF_W-1:0]    boff;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/message_log_ring_with_eviction.sv
// Top level of the message log ring with oldest-first eviction.
//
//  channel   direction  handshake               payload
//  in        into block in_valid / in_stall     mode .. byte_offset
//  out       from block out_valid / out_stall   status .. messages_dropped
//  cfg       into block cfg_wr_en               cfg_wr_data (own_sender_id)
//
//  An accepted word waits in the queue until the back end is idle. Back end
//  states: byte append S_IDLE, S_OUT; read S_IDLE, S_RD1, S_RD2, S_OUT; open
//  S_IDLE, S_LOOPCHK, S_WRDESC, S_OUT. A full ring adds S_FULLDROP; each text
//  eviction adds S_LOOPDROP and another S_LOOPCHK, reading one old descriptor.
//  Reset clears the ring pointers and counters; the stores need no clearing.
//  A two-word queue lets the input accept up to two words while a result waits on out_stall.
`default_nettype none

module message_log_ring_with_eviction #(
    parameter int MSG_SLOTS  = 64,
    parameter int TEXT_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic                          first_of_message,
    input  wire logic [mlr_pkg::LEN_W-1:0]     msg_length,
    input  wire logic [mlr_pkg::SENDER_W-1:0]  sender_id,
    input  wire logic [mlr_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic [mlr_pkg::MOFF_W-1:0]    message_offset,
    input  wire logic [mlr_pkg::BOFF_W-1:0]    byte_offset,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mlr_pkg::STATUS_W-1:0]       status,
    output logic [mlr_pkg::BYTE_W-1:0]         read_byte,
    output logic [mlr_pkg::LEN_W-1:0]          read_length,
    output logic [mlr_pkg::SENDER_W-1:0]       read_sender,
    output logic                               read_is_own,
    output logic [mlr_pkg::COUNT_W-1:0]        messages_held,
    output logic [mlr_pkg::COUNT_W-1:0]        messages_dropped,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mlr_pkg::SENDER_W-1:0]  cfg_wr_data
);

    logic [mlr_pkg::SENDER_W-1:0] own_id_reg;
    logic                         q_valid;
    logic                         q_pop;
    mlr_pkg::item_t               q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_id_reg <= '0;
        else if (cfg_wr_en)
            own_id_reg <= cfg_wr_data;
    end

    mlr_front #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .first_of_message (first_of_message),
        .msg_length       (msg_length),
        .sender_id        (sender_id),
        .data_byte        (data_byte),
        .message_offset   (message_offset),
        .byte_offset      (byte_offset),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    mlr_back #(
        .MSG_SLOTS  (MSG_SLOTS),
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .own_id           (own_id_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .read_byte        (read_byte),
        .read_length      (read_length),
        .read_sender      (read_sender),
        .read_is_own      (read_is_own),
        .messages_held    (messages_held),
        .messages_dropped (messages_dropped)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mlr_front.sv
// Input side: classifies each word and queues it for the back end.
`default_nettype none

module mlr_front #(
    parameter int TEXT_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          mode,
    input  wire logic                          first_of_message,
    input  wire logic [mlr_pkg::LEN_W-1:0]     msg_length,
    input  wire logic [mlr_pkg::SENDER_W-1:0]  sender_id,
    input  wire logic [mlr_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic [mlr_pkg::MOFF_W-1:0]    message_offset,
    input  wire logic [mlr_pkg::BOFF_W-1:0]    byte_offset,
    output logic                               q_valid,
    output mlr_pkg::item_t                     q_item,
    input  wire logic                          q_pop
);

    mlr_pkg::item_t queue_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    mlr_pkg::item_t item_in;
    logic           push;

    always_comb
    begin
        item_in.len    = msg_length;
        item_in.sender = sender_id;
        item_in.data   = data_byte;
        item_in.moff   = message_offset;
        item_in.boff   = byte_offset;
        if (mode)
            item_in.kind = mlr_pkg::KIND_READ;
        else if (first_of_message && (32'(msg_length) > TEXT_DEPTH))
            item_in.kind = mlr_pkg::KIND_REJECT;
        else if (first_of_message)
            item_in.kind = mlr_pkg::KIND_OPEN;
        else
            item_in.kind = mlr_pkg::KIND_BYTE;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= item_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) && !q_pop |=> (count_reg == 2'd2))
        else $error("queue lost an entry");

endmodule

`default_nettype wire

FILE: rtl/core/mlr_back.sv
// Execution side: descriptor ring, text store, eviction walk and result register.
`default_nettype none

module mlr_back #(
    parameter int MSG_SLOTS  = 64,
    parameter int TEXT_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire mlr_pkg::item_t                q_item,
    output logic                               q_pop,
    input  wire logic [mlr_pkg::SENDER_W-1:0]  own_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mlr_pkg::STATUS_W-1:0]       status,
    output logic [mlr_pkg::BYTE_W-1:0]         read_byte,
    output logic [mlr_pkg::LEN_W-1:0]          read_length,
    output logic [mlr_pkg::SENDER_W-1:0]       read_sender,
    output logic                               read_is_own,
    output logic [mlr_pkg::COUNT_W-1:0]        messages_held,
    output logic [mlr_pkg::COUNT_W-1:0]        messages_dropped
);

    localparam int SW   = $clog2(MSG_SLOTS);
    localparam int TW   = $clog2(TEXT_DEPTH);
    localparam int UW   = $clog2(TEXT_DEPTH + 1) + 1;
    localparam int HW   = SW + mlr_pkg::COUNT_W;
    localparam int XW   = ((TW > mlr_pkg::LEN_W) ? TW : mlr_pkg::LEN_W) + 1;
    localparam int SUMW = ((UW > mlr_pkg::LEN_W) ? UW : mlr_pkg::LEN_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULLDROP,
        S_LOOPCHK,
        S_LOOPDROP,
        S_WRDESC,
        S_RD1,
        S_RD2,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [mlr_pkg::LEN_W-1:0]    ds_len_mem   [MSG_SLOTS];
    logic [TW-1:0]                ds_start_mem [MSG_SLOTS];
    logic [mlr_pkg::SENDER_W-1:0] ds_send_mem  [MSG_SLOTS];
    logic [mlr_pkg::BYTE_W-1:0]   text_mem     [TEXT_DEPTH];

    logic [mlr_pkg::LEN_W-1:0]    ds_len_rd;
    logic [TW-1:0]                ds_start_rd;
    logic [mlr_pkg::SENDER_W-1:0] ds_send_rd;
    logic [mlr_pkg::BYTE_W-1:0]   text_rd;

    logic [SW-1:0]                oldest_reg, next_reg, alloc_reg;
    logic [TW-1:0]                oldest_text_reg, next_text_reg, wr_pos_reg;
    logic [UW-1:0]                used_reg;
    logic [mlr_pkg::LEN_W-1:0]    left_reg;
    mlr_pkg::item_t               cur_reg;

    logic [mlr_pkg::STATUS_W-1:0] status_reg;
    logic [mlr_pkg::BYTE_W-1:0]   rbyte_reg;
    logic [mlr_pkg::LEN_W-1:0]    rlen_reg;
    logic [mlr_pkg::SENDER_W-1:0] rsend_reg;
    logic                         rown_reg;
    logic [mlr_pkg::COUNT_W-1:0]  dropped_reg;

    logic [SW:0]                  held_tmp, slot_sum;
    logic [SW-1:0]                held, read_slot, desc_raddr;
    logic [HW-1:0]                held_x, moff_x;
    logic [XW-1:0]                drop_pos_sum, open_end_sum, rd_addr_sum;
    logic [TW-1:0]                drop_pos, open_end, text_raddr, open_wr_pos;
    logic [SUMW-1:0]              need_sum;
    logic                         desc_we, text_we;
    logic [TW-1:0]                text_waddr;
    logic [mlr_pkg::BYTE_W-1:0]   text_wdata;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (32'(s) == MSG_SLOTS - 1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [TW-1:0] pos_inc(input logic [TW-1:0] p);
        pos_inc = (32'(p) == TEXT_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TW-1:0] pos_wrap(input logic [XW-1:0] v);
        pos_wrap = (32'(v) >= TEXT_DEPTH) ? TW'(v - XW'(TEXT_DEPTH)) : TW'(v);
    endfunction

    always_comb
    begin
        held_tmp = {1'b0, next_reg} + (SW+1)'(MSG_SLOTS) - {1'b0, oldest_reg};
        held     = (32'(held_tmp) >= MSG_SLOTS) ? SW'(held_tmp - (SW+1)'(MSG_SLOTS))
                                                : SW'(held_tmp);
        held_x   = HW'(held);
        moff_x   = HW'(q_item.moff);

        slot_sum  = {1'b0, oldest_reg} + (SW+1)'(q_item.moff);
        read_slot = (32'(slot_sum) >= MSG_SLOTS) ? SW'(slot_sum - (SW+1)'(MSG_SLOTS))
                                                 : SW'(slot_sum);
        desc_raddr = (state_reg == S_IDLE && q_item.kind == mlr_pkg::KIND_READ)
                   ? read_slot : oldest_reg;

        drop_pos_sum = XW'(oldest_text_reg) + XW'(ds_len_rd);
        drop_pos     = pos_wrap(drop_pos_sum);
        open_end_sum = XW'(next_text_reg) + XW'(cur_reg.len);
        open_end     = pos_wrap(open_end_sum);
        open_wr_pos  = pos_inc(next_text_reg);
        rd_addr_sum  = XW'(ds_start_rd) + XW'(cur_reg.boff);
        text_raddr   = pos_wrap(rd_addr_sum);
        need_sum     = SUMW'(used_reg) + SUMW'(cur_reg.len);

        desc_we = (state_reg == S_WRDESC);
        if (state_reg == S_WRDESC)
        begin
            text_we    = (cur_reg.len != '0);
            text_waddr = next_text_reg;
            text_wdata = cur_reg.data;
        end
        else
        begin
            text_we    = (state_reg == S_IDLE) && q_valid &&
                         (q_item.kind == mlr_pkg::KIND_BYTE) && (left_reg != '0);
            text_waddr = wr_pos_reg;
            text_wdata = q_item.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            ds_len_mem[alloc_reg]   <= cur_reg.len;
            ds_start_mem[alloc_reg] <= next_text_reg;
            ds_send_mem[alloc_reg]  <= cur_reg.sender;
        end
        ds_len_rd   <= ds_len_mem[desc_raddr];
        ds_start_rd <= ds_start_mem[desc_raddr];
        ds_send_rd  <= ds_send_mem[desc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
            text_mem[text_waddr] <= text_wdata;
        text_rd <= text_mem[text_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            oldest_reg      <= '0;
            next_reg        <= '0;
            alloc_reg       <= '0;
            oldest_text_reg <= '0;
            next_text_reg   <= '0;
            wr_pos_reg      <= '0;
            used_reg        <= '0;
            left_reg        <= '0;
            dropped_reg     <= '0;
            cur_reg         <= '0;
            status_reg      <= mlr_pkg::ST_OK;
            rbyte_reg       <= '0;
            rlen_reg        <= '0;
            rsend_reg       <= '0;
            rown_reg        <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg     <= q_item;
                        dropped_reg <= '0;
                        status_reg  <= mlr_pkg::ST_OK;
                        rbyte_reg   <= '0;
                        rlen_reg    <= '0;
                        rsend_reg   <= '0;
                        rown_reg    <= 1'b0;
                        case (q_item.kind)
                            mlr_pkg::KIND_REJECT:
                            begin
                                status_reg <= mlr_pkg::ST_TOO_LONG;
                                left_reg   <= '0;
                                state_reg  <= S_OUT;
                            end
                            mlr_pkg::KIND_OPEN:
                            begin
                                if (32'(held) == MSG_SLOTS - 1)
                                    state_reg <= S_FULLDROP;
                                else
                                begin
                                    alloc_reg <= next_reg;
                                    next_reg  <= slot_inc(next_reg);
                                    state_reg <= S_LOOPCHK;
                                end
                            end
                            mlr_pkg::KIND_READ:
                            begin
                                if (moff_x >= held_x)
                                begin
                                    status_reg <= mlr_pkg::ST_MISS;
                                    state_reg  <= S_OUT;
                                end
                                else
                                    state_reg <= S_RD1;
                            end
                            default:
                            begin
                                // a byte with no message open is dropped
                                if (left_reg != '0)
                                begin
                                    wr_pos_reg <= pos_inc(wr_pos_reg);
                                    left_reg   <= left_reg - 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FULLDROP, S_LOOPDROP:
                begin
                    oldest_reg      <= slot_inc(oldest_reg);
                    oldest_text_reg <= drop_pos;
                    used_reg        <= (used_reg >= UW'(ds_len_rd))
                                     ? used_reg - UW'(ds_len_rd) : '0;
                    dropped_reg     <= dropped_reg + 1'b1;
                    if (state_reg == S_FULLDROP)
                    begin
                        alloc_reg <= next_reg;
                        next_reg  <= slot_inc(next_reg);
                    end
                    state_reg <= S_LOOPCHK;
                end
                S_LOOPCHK:
                begin
                    // keep evicting while the text does not fit, never the new one
                    if ((32'(need_sum) > TEXT_DEPTH) && (held > SW'(1)))
                        state_reg <= S_LOOPDROP;
                    else
                        state_reg <= S_WRDESC;
                end
                S_WRDESC:
                begin
                    used_reg      <= UW'(need_sum);
                    next_text_reg <= open_end;
                    if (cur_reg.len != '0)
                    begin
                        wr_pos_reg <= open_wr_pos;
                        left_reg   <= cur_reg.len - 1'b1;
                    end
                    else
                        left_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_RD1:
                begin
                    rlen_reg  <= ds_len_rd;
                    rsend_reg <= ds_send_rd;
                    rown_reg  <= (ds_send_rd == own_id);
                    if (mlr_pkg::LEN_W'(cur_reg.boff) >= ds_len_rd)
                    begin
                        status_reg <= mlr_pkg::ST_MISS;
                        state_reg  <= S_OUT;
                    end
                    else
                        state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    rbyte_reg <= text_rd;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign q_pop            = (state_reg == S_IDLE) && q_valid;
    assign out_valid        = (state_reg == S_OUT);
    assign status           = status_reg;
    assign read_byte        = rbyte_reg;
    assign read_length      = rlen_reg;
    assign read_sender      = rsend_reg;
    assign read_is_own      = rown_reg;
    assign messages_held    = held_x[mlr_pkg::COUNT_W-1:0];
    assign messages_dropped = dropped_reg;

    a_desc_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRDESC) |=> (state_reg == S_OUT))
        else $error("descriptor write not followed by result");
    a_text_we_src: assert property (@(posedge clk) disable iff (!rst_n)
        text_we |-> ((state_reg == S_WRDESC) || (left_reg != '0)))
        else $error("text write with no open message");
    a_ring_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOPCHK) |-> (held != '0))
        else $error("new message slot missing during eviction");
    a_read_ok_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_reg != mlr_pkg::ST_OK) |-> (rbyte_reg == '0))
        else $error("byte returned on a failed item");

endmodule

`default_nettype wire
